>>> src/efx_pkg.sv
// Shared types, constants and the escape classifier for the escaped frame encoder.
package efx_pkg;

   localparam logic [7:0] FLAG_BYTE   = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE = 8'h5C;
   localparam logic [7:0] ESC_SRC_1   = 8'h06;
   localparam logic [7:0] ESC_SRC_2   = 8'h15;
   localparam logic [7:0] ESC_SRC_3   = 8'h11;
   localparam logic [7:0] ESC_SRC_4   = 8'h13;

   localparam logic [2:0] CODE_FLAG   = 3'd0;
   localparam logic [2:0] CODE_ESCAPE = 3'd1;
   localparam logic [2:0] CODE_SRC_1  = 3'd2;
   localparam logic [2:0] CODE_SRC_2  = 3'd3;
   localparam logic [2:0] CODE_SRC_3  = 3'd4;
   localparam logic [2:0] CODE_SRC_4  = 3'd5;

   // Escape decision for one byte: esc set means the byte goes out as
   // the escape byte followed by code.
   typedef struct packed {
      logic       esc;
      logic [2:0] code;
   } esc_type;

   // One classified payload byte, as the front end hands it to the back end.
   typedef struct packed {
      logic       first;
      logic       last;
      logic [7:0] data_byte;
      esc_type    data_esc;
      logic [7:0] sum_byte;
      esc_type    sum_esc;
   } desc_type;

   // Output sequencer steps for one payload byte.
   typedef enum logic [2:0] {
      STEP_OPEN,
      STEP_DATA,
      STEP_DATA_CODE,
      STEP_SUM,
      STEP_SUM_CODE,
      STEP_CLOSE
   } step_type;

   function automatic esc_type classify(input logic [7:0] b);
      esc_type r;
      r.esc  = 1'b1;
      r.code = CODE_FLAG;
      unique case (b)
         FLAG_BYTE:   r.code = CODE_FLAG;
         ESCAPE_BYTE: r.code = CODE_ESCAPE;
         ESC_SRC_1:   r.code = CODE_SRC_1;
         ESC_SRC_2:   r.code = CODE_SRC_2;
         ESC_SRC_3:   r.code = CODE_SRC_3;
         ESC_SRC_4:   r.code = CODE_SRC_4;
         default:     r.esc  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> src/efx_front.sv
// Front end: keeps the running XOR checksum and classifies each accepted byte.
module efx_front
   import efx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       first_byte,
   input  logic       last_byte,
   output desc_type   desc
);

   logic [7:0] xor_ff;
   logic [7:0] xor_in;
   logic [7:0] sum;

   // A first byte starts the checksum afresh.
   assign sum = (first_byte ? 8'h00 : xor_ff) ^ data_byte;

   always_comb begin
      xor_in = xor_ff;
      if (accept) begin
         xor_in = last_byte ? 8'h00 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_ff <= 8'h00;
      end else begin
         xor_ff <= xor_in;
      end
   end

   always_comb begin
      desc.first     = first_byte;
      desc.last      = last_byte;
      desc.data_byte = data_byte;
      desc.data_esc  = classify(data_byte);
      desc.sum_byte  = sum;
      desc.sum_esc   = classify(sum);
   end

endmodule

>>> src/efx_queue.sv
// Short FIFO of classified bytes between the front end and the back end.
module efx_queue
   import efx_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output desc_type head_data,
   output logic     head_valid,
   output logic     full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/efx_back.sv
// Back end: steps through the line bytes of each queued payload byte.
module efx_back
   import efx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  desc_type   head_data,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end
);

   step_type   step_ff;
   step_type   step_in;
   step_type   cur_step;
   logic       advance;
   logic       done;
   logic [7:0] line_byte;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;

   assign advance = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      cur_step = step_ff;
      if (step_ff == STEP_OPEN && !head_data.first) begin
         cur_step = STEP_DATA;
      end
   end

   always_comb begin
      step_in   = step_ff;
      done      = 1'b0;
      line_byte = FLAG_BYTE;
      unique case (cur_step)
         STEP_OPEN: begin
            line_byte = FLAG_BYTE;
            step_in   = STEP_DATA;
         end
         STEP_DATA: begin
            if (head_data.data_esc.esc) begin
               line_byte = ESCAPE_BYTE;
               step_in   = STEP_DATA_CODE;
            end else begin
               line_byte = head_data.data_byte;
               step_in   = head_data.last ? STEP_SUM : STEP_OPEN;
               done      = !head_data.last;
            end
         end
         STEP_DATA_CODE: begin
            line_byte = {5'b00000, head_data.data_esc.code};
            step_in   = head_data.last ? STEP_SUM : STEP_OPEN;
            done      = !head_data.last;
         end
         STEP_SUM: begin
            if (head_data.sum_esc.esc) begin
               line_byte = ESCAPE_BYTE;
               step_in   = STEP_SUM_CODE;
            end else begin
               line_byte = head_data.sum_byte;
               step_in   = STEP_CLOSE;
            end
         end
         STEP_SUM_CODE: begin
            line_byte = {5'b00000, head_data.sum_esc.code};
            step_in   = STEP_CLOSE;
         end
         STEP_CLOSE: begin
            line_byte = FLAG_BYTE;
            step_in   = STEP_OPEN;
            done      = 1'b1;
         end
         default: begin
            step_in = STEP_OPEN;
         end
      endcase
      if (!advance) begin
         step_in = step_ff;
      end
   end

   assign pop      = advance && done;
   assign valid_in = advance || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_OPEN;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= line_byte;
         end_ff  <= done;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_end  = end_ff;

endmodule

>>> src/escaped_frame_encoder_xor_top.sv
// Top level of the byte-stuffing frame encoder with XOR checksum.
//
// This block frames payload bytes for a serial line. Each transfer on the req
// channel carries one raw byte with first and last marks; the rsp channel
// returns the line bytes it causes, one per transfer, with run_end set on the
// last of them. A first byte is preceded by an unescaped 0x7E flag and
// restarts the XOR checksum. Every payload byte equal to 0x7E, 0x5C, 0x06,
// 0x15, 0x11 or 0x13 goes out as 0x5C followed by a code from 0 to 5, and all
// other bytes pass unchanged. A last byte is followed by the escaped checksum
// and a closing 0x7E, after which the checksum returns to zero. The front end
// accepts one byte per cycle whenever its queue of QUEUE_DEPTH entries has
// room; the back end sends exactly one line byte per cycle into a registered
// output stage while rsp_ready does not hold that stage. A payload byte yields
// its own line byte, preceded by a flag if it is first and by 0x5C if it is
// escaped; a last byte adds the checksum, escaped if needed, and a closing
// flag. The single output byte per cycle sets the sustained rate, so escape
// bytes and frame flags lower the rate at which payload bytes pass.
module escaped_frame_encoder_xor_top
   import efx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end
);

   desc_type front_desc;
   desc_type head_desc;
   logic     q_full;
   logic     q_head_valid;
   logic     q_pop;
   logic     req_xfer;

   // The request side is ready whenever the queue has a free entry.
   assign req_ready = !q_full;
   assign req_xfer  = req_valid && req_ready;

   // The front end folds the byte into the checksum and decides, for both
   // the byte and the checksum it may close with, whether escaping applies.
   efx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_xfer),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .last_byte  (req_last_byte),
      .desc       (front_desc)
   );

   // The queue decouples intake from the slower line side.
   efx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_xfer),
      .push_data  (front_desc),
      .pop        (q_pop),
      .head_data  (head_desc),
      .head_valid (q_head_valid),
      .full       (q_full)
   );

   // The back end walks the line bytes of the head entry and pops it once
   // its final byte has entered the output register.
   efx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_data    (head_desc),
      .head_valid   (q_head_valid),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_end  (rsp_run_end)
   );

endmodule
